// ===== hdl/priority_ready_queue_scheduler_core_assert.svh =====
// Assertion macros used by the scheduler control module.
`ifndef PRIORITY_READY_QUEUE_SCHEDULER_CORE_ASSERT_SVH
`define PRIORITY_READY_QUEUE_SCHEDULER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PRQS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PRQS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hdl/prqs_pkg.sv =====
package prqs_pkg;

    localparam int NUM_LEVELS = 8;
    localparam int NUM_TASKS  = 64;
    localparam int TASK_W     = 6;
    localparam int LVL_W      = 3;
    localparam int CPU_W      = 2;
    localparam int NOW_W      = 32;
    localparam int HOLD_W     = 16;
    localparam int ITER_W     = $clog2(NUM_TASKS);
    localparam int IN_W       = 48;
    localparam int OUT_W      = 16;
    localparam logic [HOLD_W-1:0] HOLD_RESET = 16'd10;

    typedef enum logic [1:0] {
        t_OP_ENQ   = 2'd0,
        t_OP_PICK  = 2'd1,
        t_OP_QUERY = 2'd2,
        t_OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ENQ_TAIL,
        S_ENQ_NEW,
        S_WALK,
        S_UPD,
        S_RESP
    } t_state;

    typedef struct packed {
        logic load;
        logic enq_tail;
        logic enq_new;
        logic walk_step;
        logic walk_head;
        logic upd;
        logic resp_load;
    } t_cmd;

    typedef struct packed {
        logic any_ready;
        logic may_run;
        logic link_end;
        logic walk_last;
    } t_sts;

endpackage

// ===== hdl/prqs_ctrl.sv =====
`include "priority_ready_queue_scheduler_core_assert.svh"

module prqs_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [1:0]    i_op,
    input  logic          i_out_ready,
    input  prqs_pkg::t_sts i_sts,
    output prqs_pkg::t_cmd o_cmd,
    output logic          o_in_ready,
    output logic          o_out_valid
);

    prqs_pkg::t_state r_state, n_state;
    logic r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= prqs_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            prqs_pkg::S_IDLE: begin
                if (i_accept) begin
                    if (i_op == prqs_pkg::t_OP_ENQ) begin
                        n_state = prqs_pkg::S_ENQ_TAIL;
                    end else if (i_op == prqs_pkg::t_OP_PICK && i_sts.any_ready) begin
                        n_state = prqs_pkg::S_WALK;
                    end else begin
                        n_state = prqs_pkg::S_RESP;
                    end
                end
            end
            prqs_pkg::S_ENQ_TAIL: n_state = prqs_pkg::S_ENQ_NEW;
            prqs_pkg::S_ENQ_NEW:  n_state = prqs_pkg::S_RESP;
            prqs_pkg::S_WALK: begin
                if (i_sts.may_run || i_sts.link_end || i_sts.walk_last) begin
                    n_state = prqs_pkg::S_UPD;
                end
            end
            prqs_pkg::S_UPD: n_state = prqs_pkg::S_RESP;
            prqs_pkg::S_RESP: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = prqs_pkg::S_IDLE;
                end
            end
            default: n_state = prqs_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            prqs_pkg::S_IDLE:     o_cmd.load     = i_accept;
            prqs_pkg::S_ENQ_TAIL: o_cmd.enq_tail = 1'b1;
            prqs_pkg::S_ENQ_NEW:  o_cmd.enq_new  = 1'b1;
            prqs_pkg::S_WALK: begin
                if (!i_sts.may_run) begin
                    if (i_sts.link_end || i_sts.walk_last) begin
                        o_cmd.walk_head = 1'b1;
                    end else begin
                        o_cmd.walk_step = 1'b1;
                    end
                end
            end
            prqs_pkg::S_UPD: o_cmd.upd = 1'b1;
            prqs_pkg::S_RESP: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.resp_load = 1'b1;
                    n_out_valid     = 1'b1;
                end
            end
            default: o_cmd = '0;
        endcase
    end

    assign o_in_ready  = (r_state == prqs_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;

    `PRQS_ASSERT_NEXT(a_walk_bounded,
                      r_state == prqs_pkg::S_WALK && i_sts.walk_last,
                      r_state != prqs_pkg::S_WALK)
    `PRQS_ASSERT_NEXT(a_upd_to_resp, r_state == prqs_pkg::S_UPD, r_state == prqs_pkg::S_RESP)
    `PRQS_ASSERT_NEXT(a_resp_loads, r_state == prqs_pkg::S_RESP && !r_out_valid, r_out_valid)

endmodule

// ===== hdl/prqs_datapath.sv =====
module prqs_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  prqs_pkg::t_cmd              i_cmd,
    input  logic [1:0]                  i_op,
    input  logic [prqs_pkg::IN_W-1:0]   i_in_data,
    input  logic                        i_cfg_we,
    input  logic [prqs_pkg::HOLD_W-1:0] i_cfg_wdata,
    output prqs_pkg::t_sts              o_sts,
    output logic [prqs_pkg::OUT_W-1:0]  o_out_data
);

    localparam int TW = prqs_pkg::TASK_W;
    localparam int LW = prqs_pkg::LVL_W;
    localparam int CW = prqs_pkg::CPU_W;
    localparam int NW = prqs_pkg::NOW_W;
    localparam int NL = prqs_pkg::NUM_LEVELS;
    localparam int NT = prqs_pkg::NUM_TASKS;

    logic [prqs_pkg::HOLD_W-1:0] r_hold;
    logic [1:0]     r_op;
    logic [TW-1:0]  r_tid;
    logic [LW-1:0]  r_pri;
    logic [CW-1:0]  r_cpu;
    logic [NW-1:0]  r_now;
    logic [LW-1:0]  r_lv;
    logic [TW-1:0]  r_cur, n_cur;
    logic [TW-1:0]  r_prev;
    logic           r_has_prev;
    logic [prqs_pkg::ITER_W-1:0] r_iter;
    logic [TW-1:0]  r_pick;
    logic           r_pick_valid;
    logic [prqs_pkg::OUT_W-1:0] r_out;

    logic [TW-1:0]  r_head [NL];
    logic [TW-1:0]  r_tail [NL];
    logic [NL-1:0]  r_nonempty;
    logic [NT-1:0]  r_aff_valid;

    logic [TW:0]      r_link_mem [NT];
    logic [TW:0]      r_link_q;
    logic [CW+NW-1:0] r_aff_mem [NT];
    logic [CW+NW-1:0] r_aff_q;
    logic             r_aff_vq;

    logic [LW-1:0]  pe_lv;
    logic [LW-1:0]  in_pri;
    logic           link_we;
    logic [TW-1:0]  link_waddr;
    logic [TW:0]    link_wdata;
    logic [CW-1:0]  aff_last;
    logic [NW-1:0]  aff_hold;
    logic [NW-1:0]  new_hold;
    logic [NL-1:0]  lower_mask;
    logic           higher_ready;
    logic           same_ready;

    assign in_pri = i_in_data[8:6];

    always_comb begin
        pe_lv = '0;
        for (int i = NL - 1; i >= 0; i--) begin
            if (r_nonempty[i]) begin
                pe_lv = LW'(i);
            end
        end
    end

    assign aff_last = r_aff_q[CW+NW-1:NW];
    assign aff_hold = r_aff_q[NW-1:0];

    always_comb begin
        n_cur = r_cur;
        if (i_cmd.load) begin
            n_cur = r_head[pe_lv];
        end else if (i_cmd.walk_step) begin
            n_cur = r_link_q[TW-1:0];
        end else if (i_cmd.walk_head) begin
            n_cur = r_head[r_lv];
        end
    end

    always_comb begin
        link_we    = 1'b0;
        link_waddr = r_tid;
        link_wdata = {1'b1, {TW{1'b0}}};
        if (i_cmd.enq_tail) begin
            link_we    = r_nonempty[r_pri];
            link_waddr = r_tail[r_pri];
            link_wdata = {1'b0, r_tid};
        end else if (i_cmd.enq_new) begin
            link_we    = 1'b1;
        end else if (i_cmd.upd) begin
            link_we    = r_has_prev;
            link_waddr = r_prev;
            link_wdata = r_link_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (link_we) begin
            r_link_mem[link_waddr] <= link_wdata;
        end
        r_link_q <= r_link_mem[n_cur];
    end

    assign new_hold = (!r_aff_vq || aff_last != r_cpu)
                    ? r_now + NW'(r_hold) : aff_hold;

    always_ff @(posedge i_clk) begin
        if (i_cmd.upd) begin
            r_aff_mem[r_cur] <= {r_cpu, new_hold};
        end
        r_aff_q <= r_aff_mem[n_cur];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold      <= prqs_pkg::HOLD_RESET;
            r_nonempty  <= '0;
            r_aff_valid <= '0;
            r_aff_vq    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_hold <= i_cfg_wdata;
            end
            r_aff_vq <= r_aff_valid[n_cur];
            if (i_cmd.enq_new) begin
                r_nonempty[r_pri] <= 1'b1;
            end
            if (i_cmd.upd) begin
                r_aff_valid[r_cur] <= 1'b1;
                if (!r_has_prev && r_link_q[TW]) begin
                    r_nonempty[r_lv] <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur <= n_cur;
        if (i_cmd.load) begin
            r_op         <= i_op;
            r_tid        <= i_in_data[5:0];
            r_pri        <= in_pri;
            r_cpu        <= i_in_data[10:9];
            r_now        <= i_in_data[42:11];
            r_lv         <= pe_lv;
            r_has_prev   <= 1'b0;
            r_iter       <= '0;
            r_pick       <= '0;
            r_pick_valid <= 1'b0;
        end
        if (i_cmd.walk_step) begin
            r_prev     <= r_cur;
            r_has_prev <= 1'b1;
            r_iter     <= r_iter + 1'b1;
        end
        if (i_cmd.walk_head) begin
            r_has_prev <= 1'b0;
        end
        if (i_cmd.enq_new) begin
            r_tail[r_pri] <= r_tid;
            if (!r_nonempty[r_pri]) begin
                r_head[r_pri] <= r_tid;
            end
        end
        if (i_cmd.upd) begin
            r_pick       <= r_cur;
            r_pick_valid <= 1'b1;
            if (r_has_prev) begin
                if (r_link_q[TW]) begin
                    r_tail[r_lv] <= r_prev;
                end
            end else if (!r_link_q[TW]) begin
                r_head[r_lv] <= r_link_q[TW-1:0];
            end
        end
        if (i_cmd.resp_load) begin
            r_out <= {{(prqs_pkg::OUT_W-9){1'b0}}, same_ready, higher_ready,
                      r_pick_valid, r_pick};
        end
    end

    always_comb begin
        for (int i = 0; i < NL; i++) begin
            lower_mask[i] = (LW'(i) < r_pri);
        end
    end

    assign higher_ready = (r_op == prqs_pkg::t_OP_QUERY) && |(r_nonempty & lower_mask);
    assign same_ready   = (r_op == prqs_pkg::t_OP_QUERY) && r_nonempty[r_pri];

    assign o_sts.any_ready = |r_nonempty;
    assign o_sts.may_run   = !r_aff_vq || aff_last == r_cpu || aff_hold < r_now;
    assign o_sts.link_end  = r_link_q[TW];
    assign o_sts.walk_last = (r_iter == prqs_pkg::ITER_W'(NT - 1));
    assign o_out_data      = r_out;

endmodule

// ===== hdl/priority_ready_queue_scheduler_core.sv =====
// Sequence: a query, an unused op or a pick on an empty queue goes from accept straight to
// the response state; an enqueue first passes the tail-link and new-entry states.
// A pick of a ready task walks the list, one link per cycle as the link memory is read,
// then passes the update state before the response state.
// One item is processed at a time; the next item is accepted once the result is registered.
// Synchronous active-low reset empties all levels, clears affinity and sets move_hold to 10.
module priority_ready_queue_scheduler_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // task_id[5:0], priority_req[8:6], cpu_id[10:9], now[42:11]
    input  logic [1:0]  s_axis_tuser,  // op[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // picked_task[5:0], picked_valid[6], higher_ready[7], same_ready[8]
    output logic [15:0] m_axis_tdata,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata
);

    prqs_pkg::t_cmd cmd;
    prqs_pkg::t_sts sts;
    logic           accept;

    assign accept = s_axis_tvalid && s_axis_tready;

    prqs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_op        (s_axis_tuser),
        .i_out_ready (m_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid)
    );

    prqs_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_op        (s_axis_tuser),
        .i_in_data   (s_axis_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_sts       (sts),
        .o_out_data  (m_axis_tdata)
    );

endmodule
